>>> rtl/prime_filter_trial_division_top_macros.svh
// Assertion macros for the prime filter.
// Each expects clk and rst_n in scope.
`ifndef PRIME_FILTER_TRIAL_DIVISION_TOP_MACROS_SVH
`define PRIME_FILTER_TRIAL_DIVISION_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define PFT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PFT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFT_ASSERT_IMP(label, ante, cons, msg)

`define PFT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/pft_pkg.sv
package pft_pkg;

    localparam int VALUE_WIDTH    = 16;
    localparam int DEST_DEPTH     = 128;
    localparam int SMALLEST_PRIME = 2;

    // magnitude of a positive value
    localparam int MAG_W  = VALUE_WIDTH - 1;
    // trial divisor never exceeds about sqrt(2^MAG_W) + 1
    localparam int DIV_W  = (MAG_W + 2) / 2;
    localparam int SQ_W   = 2 * DIV_W;
    localparam int STEP_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;
    localparam int IDX_W  = (DEST_DEPTH > 1) ? $clog2(DEST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEST_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST,
        ST_DONE
    } pft_state_t;

    typedef struct packed {
        logic load;
        logic start_div;
        logic step;
        logic set_prime;
        logic finish;
    } pft_cmd_t;

    typedef struct packed {
        logic below_two;
        logic sq_gt_n;
        logic div_done;
        logic rem_zero;
        logic out_free;
    } pft_stat_t;

endpackage

>>> rtl/pft_rem.sv
`include "prime_filter_trial_division_top_macros.svh"

module pft_rem
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pft_pkg::MAG_W-1:0]  dividend,
    input  logic [pft_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [pft_pkg::DIV_W-1:0]  rem
);
    import pft_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   cnt_reg,   cnt_next;
    logic [MAG_W-1:0]    shift_reg, shift_next;
    logic [DIV_W-1:0]    div_reg,   div_next;
    logic [DIV_W-1:0]    rem_reg,   rem_next;
    logic [DIV_W:0]      trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, shift_reg[MAG_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[DIV_W-1:0];
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `PFT_ASSERT_IMP(a_rem_below_div, done_reg, rem_reg < div_reg, "remainder not below divisor")
    `PFT_ASSERT_NXT(a_start_busy, start, busy_reg && !done_reg, "start did not launch division")

endmodule

>>> rtl/pft_ctrl.sv
module pft_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pft_pkg::pft_stat_t stat,
    output pft_pkg::pft_cmd_t  cmd
);
    import pft_pkg::*;

    pft_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.below_two || stat.sq_gt_n)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (stat.rem_zero)
                    state_next = ST_DONE;
                else
                    state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                cmd.set_prime = !stat.below_two && stat.sq_gt_n;
                cmd.start_div = !stat.below_two && !stat.sq_gt_n;
            end
            ST_DIVIDE: ;
            ST_TEST:
            begin
                cmd.step = !stat.rem_zero;
            end
            ST_DONE:
            begin
                cmd.finish = stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/pft_dp.sv
`include "prime_filter_trial_division_top_macros.svh"

module pft_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pft_pkg::VALUE_WIDTH-1:0]   value,
    input  logic                              last,
    input  pft_pkg::pft_cmd_t                 cmd,
    output pft_pkg::pft_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pft_pkg::VALUE_WIDTH-1:0]   out_value,
    output logic                              is_prime,
    output logic [pft_pkg::IDX_W-1:0]         dest_index,
    output logic [pft_pkg::CNT_W-1:0]         kept_count,
    output logic                              dest_full,
    output logic                              out_last
);
    import pft_pkg::*;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   last_reg;
    logic [DIV_W-1:0]       d_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   prime_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg;

    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   is_prime_reg;
    logic [IDX_W-1:0]       dest_index_reg;
    logic [CNT_W-1:0]       kept_count_reg;
    logic                   dest_full_reg;
    logic                   out_last_reg;

    logic [MAG_W-1:0]       mag;
    logic                   div_done;
    logic [DIV_W-1:0]       rem;
    logic                   full;
    logic [IDX_W-1:0]       slot;
    logic [CNT_W-1:0]       new_count;

    pft_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (mag),
        .divisor  (d_reg),
        .done     (div_done),
        .rem      (rem)
    );

    assign mag = val_reg[MAG_W-1:0];

    assign stat.below_two = $signed(val_reg) < $signed(VALUE_WIDTH'(SMALLEST_PRIME));
    assign stat.sq_gt_n   = sq_reg > SQ_W'(mag);
    assign stat.div_done  = div_done;
    assign stat.rem_zero  = (rem == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign full      = count_reg >= CNT_W'(DEST_DEPTH);
    assign slot      = full ? IDX_W'(DEST_DEPTH - 1) : count_reg[IDX_W-1:0];
    assign new_count = (prime_reg && !full) ? count_reg + CNT_W'(1) : count_reg;
    assign count_next = last_reg ? '0 : new_count;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg  <= value;
            last_reg <= last;
            d_reg    <= DIV_W'(SMALLEST_PRIME);
            sq_reg   <= SQ_W'(SMALLEST_PRIME * SMALLEST_PRIME);
        end
        else if (cmd.step)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            d_reg  <= d_reg + DIV_W'(1);
            sq_reg <= sq_reg + SQ_W'({d_reg, 1'b1});
        end
        if (cmd.finish)
        begin
            out_value_reg  <= val_reg;
            is_prime_reg   <= prime_reg;
            dest_index_reg <= slot;
            kept_count_reg <= new_count;
            dest_full_reg  <= prime_reg && full;
            out_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                prime_reg <= 1'b0;
            else if (cmd.set_prime)
                prime_reg <= 1'b1;
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign is_prime   = is_prime_reg;
    assign dest_index = dest_index_reg;
    assign kept_count = kept_count_reg;
    assign dest_full  = dest_full_reg;
    assign out_last   = out_last_reg;

    `PFT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(DEST_DEPTH), "prime count past depth")
    `PFT_ASSERT_IMP(a_finish_free, cmd.finish, stat.out_free, "result written over pending transfer")
    `PFT_ASSERT_IMP(a_prime_pos, cmd.set_prime, !stat.below_two, "value below two marked prime")

endmodule

>>> rtl/prime_filter_trial_division_top.sv
// Prime filter by trial division. Each transfer on the input carries one signed
// value and a last flag; each gives exactly one result transfer with the value,
// its prime flag, the destination slot a prime fills, the saturating count of
// primes kept and an overflow flag. The count clears after the item marked last.
// One item is in work at a time; a finished result waits in an output register
// while the next item is taken. Values below two skip the division. Otherwise
// each trial divisor runs the bit-serial remainder unit (one dividend bit per
// cycle), so an item takes longer the more divisors are tried, the longest for
// the worst values near the top of the range.
module prime_filter_trial_division_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pft_pkg::VALUE_WIDTH-1:0]   value,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pft_pkg::VALUE_WIDTH-1:0]   out_value,
    output logic                              is_prime,
    output logic [pft_pkg::IDX_W-1:0]         dest_index,
    output logic [pft_pkg::CNT_W-1:0]         kept_count,
    output logic                              dest_full,
    output logic                              out_last
);
    import pft_pkg::*;

    pft_cmd_t  cmd;
    pft_stat_t stat;

    pft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pft_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .last       (last),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .is_prime   (is_prime),
        .dest_index (dest_index),
        .kept_count (kept_count),
        .dest_full  (dest_full),
        .out_last   (out_last)
    );

endmodule
